// ===== rtl/tbd_pkg.sv =====
// Package for the type-bitmap decoder: job record passed from the parser
// to the emitter, result kind and reject cause codes. No dependencies.
`default_nettype none
package tbd_pkg;

  // Longest bitmap a window block may carry.
  localparam logic [7:0] MAX_WINDOW_OCTETS = 8'd32;

  localparam logic [1:0] KIND_TYPE   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] CAUSE_NONE       = 3'd0;
  localparam logic [2:0] CAUSE_BAD_LENGTH = 3'd1;
  localparam logic [2:0] CAUSE_TRUNCATED  = 3'd2;
  localparam logic [2:0] CAUSE_WIN_ORDER  = 3'd3;
  localparam logic [2:0] CAUSE_ZERO_LAST  = 3'd4;
  localparam logic [2:0] CAUSE_EMPTY      = 3'd5;

  // One unit of work for the emitter: the set bits of one bitmap octet,
  // then optionally the end-of-field status.
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] window;
    logic [4:0] position;
    logic       has_status;
    logic [1:0] kind;
    logic [2:0] cause;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/tbd_front.sv =====
// Parser front end: walks the window blocks one byte per transaction and
// turns each nonzero bitmap byte, and each end marker, into a job for the emitter. Depends on tbd_pkg.
`default_nettype none
module tbd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         item_take,
  input  wire logic [7:0]   data_byte,
  input  wire logic         byte_present,
  input  wire logic         end_of_field,
  input  wire logic         empty_ok,
  output logic              job_valid,
  output tbd_pkg::job_t     job
);
  import tbd_pkg::*;

  typedef enum logic [3:0] {
    PH_WINDOW = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_OCTETS = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cur_win_r, cur_win_nxt;
  logic [7:0] prev_win_r, prev_win_nxt;
  logic       have_prev_r, have_prev_nxt;
  logic [5:0] left_r, left_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic       any_seen_r, any_seen_nxt;
  logic [2:0] err_r, err_nxt;

  always_comb begin
    phase_nxt     = phase_r;
    cur_win_nxt   = cur_win_r;
    prev_win_nxt  = prev_win_r;
    have_prev_nxt = have_prev_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    any_seen_nxt  = any_seen_r;
    err_nxt       = err_r;
    job.mask       = 8'h00;
    job.window     = cur_win_r;
    job.position   = pos_r;
    job.has_status = 1'b0;
    job.kind       = KIND_TYPE;
    job.cause      = CAUSE_NONE;

    if (byte_present) begin
      case (phase_r)
        PH_WINDOW: begin
          cur_win_nxt = data_byte;
          phase_nxt   = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (data_byte == 8'd0 || data_byte > MAX_WINDOW_OCTETS) begin
            err_nxt   = CAUSE_BAD_LENGTH;
            phase_nxt = PH_ERROR;
          end else if (have_prev_r && cur_win_r <= prev_win_r) begin
            err_nxt   = CAUSE_WIN_ORDER;
            phase_nxt = PH_ERROR;
          end else begin
            left_nxt      = data_byte[5:0];
            pos_nxt       = 5'd0;
            prev_win_nxt  = cur_win_r;
            have_prev_nxt = 1'b1;
            phase_nxt     = PH_OCTETS;
          end
        end
        PH_OCTETS: begin
          job.mask = data_byte;
          if (data_byte != 8'd0) any_seen_nxt = 1'b1;
          pos_nxt  = pos_r + 5'd1;
          left_nxt = left_r - 6'd1;
          if (left_nxt == 6'd0) begin
            if (data_byte == 8'd0) begin
              err_nxt   = CAUSE_ZERO_LAST;
              phase_nxt = PH_ERROR;
            end else begin
              phase_nxt = PH_WINDOW;
            end
          end
        end
        PH_ERROR: begin
          // drop bytes until the end marker
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
    end

    if (end_of_field) begin
      job.has_status = 1'b1;
      if (phase_nxt == PH_ERROR) begin
        job.cause = err_nxt;
      end else if (phase_nxt != PH_WINDOW) begin
        job.cause = CAUSE_TRUNCATED;
      end else if (!any_seen_nxt && !empty_ok) begin
        job.cause = CAUSE_EMPTY;
      end
      job.kind = (job.cause != CAUSE_NONE) ? KIND_REJECT : KIND_ACCEPT;
      phase_nxt     = PH_WINDOW;
      cur_win_nxt   = 8'd0;
      prev_win_nxt  = 8'd0;
      have_prev_nxt = 1'b0;
      left_nxt      = 6'd0;
      pos_nxt       = 5'd0;
      any_seen_nxt  = 1'b0;
      err_nxt       = CAUSE_NONE;
    end
  end

  assign job_valid = item_take && (job.mask != 8'h00 || end_of_field);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WINDOW;
      cur_win_r   <= 8'd0;
      prev_win_r  <= 8'd0;
      have_prev_r <= 1'b0;
      left_r      <= 6'd0;
      pos_r       <= 5'd0;
      any_seen_r  <= 1'b0;
      err_r       <= CAUSE_NONE;
    end else if (item_take) begin
      phase_r     <= phase_nxt;
      cur_win_r   <= cur_win_nxt;
      prev_win_r  <= prev_win_nxt;
      have_prev_r <= have_prev_nxt;
      left_r      <= left_nxt;
      pos_r       <= pos_nxt;
      any_seen_r  <= any_seen_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tbd_queue.sv =====
// Job queue between parser and emitter, a small register FIFO.
// Depends on tbd_pkg for the job record.
`default_nettype none
module tbd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  tbd_pkg::job_t      wr_job,
  input  wire logic          rd_en,
  output tbd_pkg::job_t      rd_job,
  output logic               q_full,
  output logic               q_empty
);
  import tbd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == FULL_CNT);
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    if (do_wr && !do_rd) count_nxt = count_r + CW'(1);
    if (do_rd && !do_wr) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= wr_job;
  end

endmodule
`default_nettype wire

// ===== rtl/tbd_back.sv =====
// Emitter back end: holds one job and hands out one result per pop,
// type codes most significant bit first, then the status. Depends on tbd_pkg.
`default_nettype none
module tbd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  tbd_pkg::job_t      q_job,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [15:0]        type_code,
  output logic [1:0]         result_kind,
  output logic [2:0]         reject_cause,
  output logic               last_in_run
);
  import tbd_pkg::*;

  job_t       job_r, job_nxt;
  logic       valid_r, valid_nxt;
  logic [2:0] msb;
  logic [7:0] mask_rest;
  logic       emit_type;
  logic       done;
  logic       take;

  always_comb begin
    msb = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (job_r.mask[i]) msb = 3'(i);
    end
  end

  assign mask_rest = job_r.mask & ~(8'h01 << msb);
  assign emit_type = (job_r.mask != 8'h00);
  assign done      = !emit_type || (mask_rest == 8'h00 && !job_r.has_status);

  assign empty        = !valid_r;
  assign type_code    = emit_type ? {job_r.window, job_r.position, ~msb} : 16'd0;
  assign result_kind  = emit_type ? KIND_TYPE : job_r.kind;
  assign reject_cause = emit_type ? CAUSE_NONE : job_r.cause;
  assign last_in_run  = done;

  // Load the next job once the current one is gone or its last result leaves.
  assign take  = !valid_r || (pop && done);
  assign q_pop = take && !q_empty;

  always_comb begin
    job_nxt   = job_r;
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = !q_empty;
      job_nxt   = q_job;
    end else if (pop) begin
      job_nxt.mask = mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/type_bitmap_decoder_top.sv =====
// Type-bitmap decoder top level: parser front end, job queue, emitter.
// Path: with the emitter idle, a byte's job goes to a queue slot, then to the emitter's job register.
// Throughput: one result per cycle out of the emitter while pop is held and jobs are queued; a byte with k set bits
//   yields k results (8 at most), an end item one more result.
//   Bytes that yield no result pass at one per cycle while the queue has room.
// Reset: synchronous active-low rst_n clears parse state, queue, empty-field enable.
`default_nettype none
module type_bitmap_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_byte_present,
  input  wire logic         in_end_of_field,
  // result channel
  output logic              empty,
  input  wire logic         pop,
  output logic [15:0]       out_type_code,
  output logic [1:0]        out_result_kind,
  output logic [2:0]        out_reject_cause,
  output logic              out_last_in_run,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tbd_pkg::*;

  localparam logic ADDR_EMPTY_OK = 1'b0;

  logic empty_ok_r;
  logic q_full, q_empty, q_pop;
  logic item_take;
  logic job_valid;
  job_t job_in, job_head;

  // Config: one register at byte address 0; bit 2 of paddr is the index.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_EMPTY_OK) ? {31'd0, empty_ok_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_ok_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_EMPTY_OK) begin
      empty_ok_r <= pwdata[0];
    end
  end

  // Hold off the producer while the queue has no room for another job.
  assign full      = q_full;
  assign item_take = push && !full;

  tbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_take    (item_take),
    .data_byte    (in_data_byte),
    .byte_present (in_byte_present),
    .end_of_field (in_end_of_field),
    .empty_ok     (empty_ok_r),
    .job_valid    (job_valid),
    .job          (job_in)
  );

  tbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_valid),
    .wr_job  (job_in),
    .rd_en   (q_pop),
    .rd_job  (job_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  tbd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_job        (job_head),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .type_code    (out_type_code),
    .result_kind  (out_result_kind),
    .reject_cause (out_reject_cause),
    .last_in_run  (out_last_in_run)
  );

  // A status result always closes the run of its transaction.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind != KIND_TYPE) |-> out_last_in_run)
    else $error("status result not marked last in run");

  // Reject carries a cause, accept and type codes carry none.
  a_cause_match: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_result_kind == KIND_REJECT) == (out_reject_cause != CAUSE_NONE)))
    else $error("reject cause does not match result kind");

  // A pending result that is not popped stays in place.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_type_code) && $stable(out_result_kind)))
    else $error("pending result changed without pop");

endmodule
`default_nettype wire
